[rtl/rdtt_pkg.sv]
package rdtt_pkg;

    // Field widths fixed by the item format
    localparam int COORD_BITS  = 12;
    localparam int TIME_BITS   = 32;
    localparam int VALUE_BITS  = 8;
    localparam int QREG_BITS   = 4;
    localparam int SHIFT_BITS  = 4;
    localparam int DIMCFG_BITS = 5;

    // Stream widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 4;
    localparam int M_FWD_BIT = 3;

    // Register map (word index)
    localparam logic [1:0] REG_SHIFT  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_DEPTH  = 2'd3;

    localparam logic [SHIFT_BITS-1:0]  SHIFT_RST = 4'd4;
    localparam logic [DIMCFG_BITS-1:0] DIM_RST   = 5'd16;

    typedef enum logic [2:0] {
        CMD_TRACK  = 3'd0,
        CMD_LWRITE = 3'd1,
        CMD_LOCK   = 3'd2,
        CMD_UNLOCK = 3'd3,
        CMD_MARK   = 3'd4,
        CMD_QUERY  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LOCKED    = 3'd1,
        ST_NOT_LOCKED = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_BAD_LWRITE = 3'd4
    } t_status;

endpackage

[rtl/rdtt_stamp_ram.sv]
module rdtt_stamp_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/rdtt_box_walk.sv]
module rdtt_box_walk #(
    parameter int REGIONS = 16,
    localparam int RB = (REGIONS > 1) ? $clog2(REGIONS) : 1,
    localparam int AW = (REGIONS > 1) ? $clog2(REGIONS * REGIONS * REGIONS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [2:0][RB-1:0]   i_lo,
    input  logic [2:0][RB-1:0]   i_hi,
    output logic                 o_busy,
    output logic [AW-1:0]        o_addr
);

    localparam int RR = REGIONS * REGIONS;

    logic               r_busy, n_busy;
    logic [2:0][RB-1:0] r_lo, r_hi;
    logic [RB-1:0]      r_x, r_y, r_z;
    logic [RB-1:0]      n_x, n_y, n_z;

    // Advance x, then y, then z; drop busy after the last corner
    always_comb begin
        n_busy = r_busy;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        if (r_busy) begin
            if (r_x != r_hi[0]) begin
                n_x = r_x + RB'(1);
            end else begin
                n_x = r_lo[0];
                if (r_y != r_hi[1]) begin
                    n_y = r_y + RB'(1);
                end else begin
                    n_y = r_lo[1];
                    if (r_z != r_hi[2]) begin
                        n_z = r_z + RB'(1);
                    end else begin
                        n_busy = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo <= i_lo;
            r_hi <= i_hi;
            r_x  <= i_lo[0];
            r_y  <= i_lo[1];
            r_z  <= i_lo[2];
        end else begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_busy = r_busy;
    assign o_addr = AW'(r_x) + AW'(AW'(r_y) * AW'(REGIONS)) + AW'(AW'(r_z) * AW'(RR));

endmodule

[rtl/region_dirty_timestamp_tracker.sv]
// Region dirty timestamp tracker.
// Input stream (s_*): one command beat per item; tuser carries the command,
// tdata the coordinates, the voxel byte and the region to query.
// Output stream (m_*): exactly one result beat per command with status, the
// time after the command, the queried stamp and the forwarded voxel write.
// Config: APB registers region_shift, width, height and depth (in regions),
// which the user must write only while the block is idle; it is not enforced.
// Flow: one item at a time. Lock, locked write and unknown codes go from decode
// straight to the result; a query first reads the stamp table. Stamping goes
// through one box walker that writes one table entry per cycle: a tracked
// write on a region face stamps up to 27 regions, an unlock stamps its whole
// box and mark-all up to REGIONS_PER_AXIS^3 entries.
// Reset: the walker sweeps the whole stamp table to zero, one entry a cycle;
// s_tready stays low. Config writes are taken during the sweep.
// Stall: a finished result sits in the output register until m_tready; the
// next command is accepted meanwhile and waits at its end for the register.
module region_dirty_timestamp_tracker
    import rdtt_pkg::*;
#(
    parameter int REGIONS_PER_AXIS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // s_tdata: pos_x, pos_y, pos_z, upper_x, upper_y, upper_z, voxel_value,
    //          region_x, region_y, region_z (from bit 0 up), zero pad
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // s_tuser: cmd
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // m_tdata: current_time, region_time, write_x, write_y, write_z,
    //          write_value (from bit 0 up), zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // m_tuser: status, write_valid (from bit 0 up)
    output logic [M_TUSER_W-1:0] o_m_tuser,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [3:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    output logic [31:0]          o_prdata,
    output logic                 o_pready
);

    localparam int R     = REGIONS_PER_AXIS;
    localparam int RB    = (R > 1) ? $clog2(R) : 1;
    localparam int DEPTH = R * R * R;
    localparam int AW    = (R > 1) ? $clog2(DEPTH) : 1;
    localparam int RR    = R * R;
    localparam int BW    = COORD_BITS + 2;

    typedef enum logic [8:0] {
        S_CLRGO = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_IDLE  = 9'b000000100,
        S_DEC   = 9'b000001000,
        S_SETUP = 9'b000010000,
        S_WALK  = 9'b000100000,
        S_BUMP2 = 9'b001000000,
        S_QREAD = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    function automatic logic [COORD_BITS-1:0] to_region(
        input logic [COORD_BITS-1:0] c,
        input logic [SHIFT_BITS-1:0] s
    );
        return (s >= SHIFT_BITS'(COORD_BITS)) ? '0 : (c >> s);
    endfunction

    function automatic logic on_face(
        input logic [COORD_BITS-1:0] c,
        input logic [SHIFT_BITS-1:0] s
    );
        logic [15:0] mask;
        logic [15:0] rem;
        mask = (16'd1 << s) - 16'd1;
        rem  = {4'b0, c} & mask;
        return (rem == 16'd0) || (rem == mask);
    endfunction

    // Registers
    t_state                         r_state, n_state;
    t_cmd                           r_cmd;
    logic [2:0][COORD_BITS-1:0]     r_pos, r_upr;
    logic [VALUE_BITS-1:0]          r_val;
    logic [2:0][QREG_BITS-1:0]      r_q;
    logic [TIME_BITS-1:0]           r_time, n_time;
    logic                           r_held, n_held;
    logic [2:0][COORD_BITS-1:0]     r_lk_lo, n_lk_lo, r_lk_hi, n_lk_hi;
    t_status                        r_status, n_status;
    logic                           r_fwd, n_fwd;
    logic [TIME_BITS-1:0]           r_rtime, n_rtime;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_load;
    logic [M_TDATA_W-1:0]           r_out_tdata, n_out_tdata;
    logic [M_TUSER_W-1:0]           r_out_tuser, n_out_tuser;
    logic [SHIFT_BITS-1:0]          r_shift;
    logic [DIMCFG_BITS-1:0]         r_wcfg, r_hcfg, r_dcfg;

    // Shared bump unit and helpers
    logic                           w_accept;
    logic                           w_wrap;
    logic [TIME_BITS-1:0]           w_time_inc;
    logic [2:0][7:0]                w_dim;
    logic [2:0][DIMCFG_BITS-1:0]    w_cfg;
    logic                           w_face;
    logic [2:0]                     w_q_in;
    logic                           w_q_ok;
    logic [AW-1:0]                  w_q_addr;
    logic signed [2:0][BW-1:0]      w_lo, w_hi;
    logic [2:0]                     w_axis_empty;
    logic                           w_empty;
    logic                           w_wk_start, w_wk_busy;
    logic [2:0][RB-1:0]             w_wk_lo, w_wk_hi;
    logic [AW-1:0]                  w_wk_addr;
    logic [TIME_BITS-1:0]           w_wr_data;
    logic                           w_rd_en;
    logic [TIME_BITS-1:0]           w_rd_data;
    logic                           w_cfg_wr;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_wrap     = (r_time == '1);
    assign w_time_inc = r_time + TIME_BITS'(1);

    // Clip configured counts to the table size
    assign w_cfg = {r_dcfg, r_hcfg, r_wcfg};
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_dim[a] = ({3'b0, w_cfg[a]} > 8'(R)) ? 8'(R) : {3'b0, w_cfg[a]};
        end
    end

    // Query range check and table address
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_q_in[a] = ({4'b0, r_q[a]} < w_dim[a]);
        end
    end
    assign w_q_ok   = &w_q_in;
    assign w_q_addr = AW'(r_q[0]) + AW'(AW'(r_q[1]) * AW'(R)) + AW'(AW'(r_q[2]) * AW'(RR));

    // Box bounds for the walker, clipped to the volume
    assign w_face = on_face(r_pos[0], r_shift) || on_face(r_pos[1], r_shift) ||
                    on_face(r_pos[2], r_shift);

    always_comb begin
        logic signed [BW-1:0] lo;
        logic signed [BW-1:0] hi;
        logic signed [BW-1:0] dm1;
        logic signed [BW-1:0] rg;
        for (int a = 0; a < 3; a++) begin
            rg = $signed({2'b0, to_region(r_pos[a], r_shift)});
            case (r_cmd)
                CMD_TRACK: begin
                    lo = w_face ? rg - BW'(1) : rg;
                    hi = w_face ? rg + BW'(1) : rg;
                end
                CMD_UNLOCK: begin
                    lo = $signed({2'b0, to_region(r_lk_lo[a], r_shift)});
                    hi = $signed({2'b0, to_region(r_lk_hi[a], r_shift)});
                end
                default: begin
                    lo = '0;
                    hi = BW'(R - 1);
                end
            endcase
            dm1 = $signed({{(BW-8){1'b0}}, w_dim[a]}) - BW'(1);
            w_lo[a] = (lo < 0) ? '0 : lo;
            w_hi[a] = (hi > dm1) ? dm1 : hi;
            w_axis_empty[a] = ($signed(w_hi[a]) < $signed(w_lo[a]));
        end
    end
    assign w_empty = |w_axis_empty;

    // Walker start: full table sweep after reset, else the clipped box
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_wk_lo[a] = (r_state == S_CLRGO) ? '0 : RB'(w_lo[a]);
            w_wk_hi[a] = (r_state == S_CLRGO) ? RB'(R - 1) : RB'(w_hi[a]);
        end
    end
    assign w_wk_start = (r_state == S_CLRGO) || ((r_state == S_SETUP) && !w_empty);
    assign w_wr_data  = (r_state == S_CLEAR) ? '0 : r_time;
    assign w_rd_en    = (r_state == S_QREAD);

    rdtt_box_walk #(
        .REGIONS (R)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_wk_start),
        .i_lo    (w_wk_lo),
        .i_hi    (w_wk_hi),
        .o_busy  (w_wk_busy),
        .o_addr  (w_wk_addr)
    );

    rdtt_stamp_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (TIME_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wk_busy),
        .i_wr_addr (w_wk_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_q_addr),
        .o_rd_data (w_rd_data)
    );

    // Command sequencer
    always_comb begin
        n_state  = r_state;
        n_time   = r_time;
        n_held   = r_held;
        n_lk_lo  = r_lk_lo;
        n_lk_hi  = r_lk_hi;
        n_status = r_status;
        n_fwd    = r_fwd;
        n_rtime  = r_rtime;
        case (r_state)
            S_CLRGO: n_state = S_CLEAR;
            S_CLEAR: begin
                if (!w_wk_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_DEC;
                    n_status = ST_OK;
                    n_fwd    = 1'b0;
                    n_rtime  = '0;
                end
            end
            S_DEC: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_TRACK, CMD_MARK: begin
                        n_time = w_time_inc;
                        if (w_wrap) begin
                            n_status = ST_OVERFLOW;
                        end else begin
                            n_fwd   = (r_cmd == CMD_TRACK);
                            n_state = S_SETUP;
                        end
                    end
                    CMD_UNLOCK: begin
                        if (!r_held) begin
                            n_status = ST_NOT_LOCKED;
                        end else begin
                            n_time = w_time_inc;
                            if (w_wrap) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_state = S_SETUP;
                            end
                        end
                    end
                    CMD_LWRITE: begin
                        n_fwd    = r_held;
                        n_status = r_held ? ST_OK : ST_BAD_LWRITE;
                    end
                    CMD_LOCK: begin
                        if (r_held) begin
                            n_status = ST_LOCKED;
                        end else begin
                            n_held  = 1'b1;
                            n_lk_lo = r_pos;
                            n_lk_hi = r_upr;
                        end
                    end
                    CMD_QUERY: begin
                        if (w_q_ok) begin
                            n_state = S_QREAD;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SETUP: n_state = S_WALK;
            S_WALK: begin
                if (!w_wk_busy) begin
                    if (r_cmd == CMD_MARK) begin
                        n_state = S_DONE;
                    end else begin
                        if (r_cmd == CMD_UNLOCK) begin
                            n_held = 1'b0;
                        end
                        n_state = S_BUMP2;
                    end
                end
            end
            S_BUMP2: begin
                n_time = w_time_inc;
                if (w_wrap) begin
                    n_status = ST_OVERFLOW;
                end
                n_state = S_DONE;
            end
            S_QREAD: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Query data lands the cycle after the read
    logic r_q_pending;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_pending <= 1'b0;
        end else begin
            r_q_pending <= w_rd_en;
        end
    end

    // Output register load
    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        if ((r_state == S_DONE) && (!r_out_valid || i_m_tready)) begin
            n_out_valid = 1'b1;
        end
        n_out_tdata = {4'b0,
                       r_fwd ? r_val : '0,
                       r_fwd ? r_pos[2] : '0,
                       r_fwd ? r_pos[1] : '0,
                       r_fwd ? r_pos[0] : '0,
                       r_q_pending ? w_rd_data : r_rtime,
                       r_time};
        n_out_tuser = {r_fwd, r_status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLRGO;
            r_time      <= '0;
            r_held      <= 1'b0;
            r_lk_lo     <= '0;
            r_lk_hi     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_held      <= n_held;
            r_lk_lo     <= n_lk_lo;
            r_lk_hi     <= n_lk_hi;
            r_out_valid <= n_out_valid;
        end
    end

    assign r_out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    // Payload: captured item, result and output beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= t_cmd'(i_s_tuser);
            r_pos[0] <= i_s_tdata[11:0];
            r_pos[1] <= i_s_tdata[23:12];
            r_pos[2] <= i_s_tdata[35:24];
            r_upr[0] <= i_s_tdata[47:36];
            r_upr[1] <= i_s_tdata[59:48];
            r_upr[2] <= i_s_tdata[71:60];
            r_val    <= i_s_tdata[79:72];
            r_q[0]   <= i_s_tdata[83:80];
            r_q[1]   <= i_s_tdata[87:84];
            r_q[2]   <= i_s_tdata[91:88];
        end
        r_status <= n_status;
        r_fwd    <= n_fwd;
        r_rtime  <= r_q_pending ? w_rd_data : n_rtime;
        if (r_out_load) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= n_out_tuser;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

    // Configuration registers
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RST;
            r_wcfg  <= DIM_RST;
            r_hcfg  <= DIM_RST;
            r_dcfg  <= DIM_RST;
        end else if (w_cfg_wr) begin
            case (i_paddr[3:2])
                REG_SHIFT:  r_shift <= i_pwdata[SHIFT_BITS-1:0];
                REG_WIDTH:  r_wcfg  <= i_pwdata[DIMCFG_BITS-1:0];
                REG_HEIGHT: r_hcfg  <= i_pwdata[DIMCFG_BITS-1:0];
                REG_DEPTH:  r_dcfg  <= i_pwdata[DIMCFG_BITS-1:0];
                default:    r_shift <= r_shift;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            REG_SHIFT:  o_prdata = {28'b0, r_shift};
            REG_WIDTH:  o_prdata = {27'b0, r_wcfg};
            REG_HEIGHT: o_prdata = {27'b0, r_hcfg};
            REG_DEPTH:  o_prdata = {27'b0, r_dcfg};
            default:    o_prdata = '0;
        endcase
    end

endmodule

[rtl/rdtt_checker.sv]
module rdtt_checker
    import rdtt_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic [M_TUSER_W-1:0] o_m_tuser
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result beat changed");

    // Table sweep keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_s_tready)
        else $error("input open during table sweep");

    // One command at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input open while a command is in work");

    // Unforwarded writes carry zero write fields
    a_fwd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[M_FWD_BIT] |-> (o_m_tdata[107:64] == '0))
        else $error("write fields set without write_valid");

    // Time overflow status always reports a wrapped counter
    a_ovf_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[2:0] == ST_OVERFLOW) |-> (o_m_tdata[31:0] == '0))
        else $error("overflow status with nonzero time");

endmodule

bind region_dirty_timestamp_tracker rdtt_checker u_rdtt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import rdtt_pkg::*;

    localparam int REGIONS     = 16;
    localparam int CYCLE_LIMIT = 6000000;

    // Reserved command codes the block must ignore
    localparam logic [2:0] CMD_RSVD_A = 3'd6;
    localparam logic [2:0] CMD_RSVD_B = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [11:0] pos_x, pos_y, pos_z;
        logic [11:0] up_x, up_y, up_z;
        logic [7:0]  value;
        logic [3:0]  reg_x, reg_y, reg_z;
    } command_t;

    typedef struct {
        t_status     status;
        logic [31:0] current_time;
        logic [31:0] region_time;
        logic        write_valid;
        logic [11:0] write_x, write_y, write_z;
        logic [7:0]  write_value;
    } stamp_result_t;

    // Tracks region stamps, time and lock box; predicts one result per command
    class region_stamp_scoreboard;
        bit [31:0]     stamps [REGIONS*REGIONS*REGIONS];
        bit [31:0]     clock_value;
        bit            box_held;
        int            box_lo [3];
        int            box_hi [3];
        int            shift_cfg;
        int            dim_cfg [3];
        stamp_result_t expected_results [$];
        int            errors;

        function new();
            foreach (stamps[i]) stamps[i] = '0;
            clock_value = '0;
            box_held    = 1'b0;
            box_lo      = '{0, 0, 0};
            box_hi      = '{0, 0, 0};
            shift_cfg   = 4;
            dim_cfg     = '{16, 16, 16};
            errors      = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_SHIFT:  shift_cfg  = int'(value[3:0]);
                REG_WIDTH:  dim_cfg[0] = int'(value[4:0]);
                REG_HEIGHT: dim_cfg[1] = int'(value[4:0]);
                REG_DEPTH:  dim_cfg[2] = int'(value[4:0]);
                default: ;
            endcase
        endfunction

        function int dim_of(int axis);
            return (dim_cfg[axis] > REGIONS) ? REGIONS : dim_cfg[axis];
        endfunction

        // Advance time; report a wrap
        function bit bump_time();
            if (clock_value == '1) begin
                clock_value = '0;
                return 1'b1;
            end
            clock_value = clock_value + 1;
            return 1'b0;
        endfunction

        function int region_of(logic [11:0] c);
            return (shift_cfg >= COORD_BITS) ? 0 : int'(c >> shift_cfg);
        endfunction

        function bit on_face(logic [11:0] c);
            int side;
            int r;
            side = 1 << shift_cfg;
            r    = int'(c) & (side - 1);
            return (r == 0) || (r == side - 1);
        endfunction

        // Stamp an inclusive box, clipped to the configured volume
        function void stamp_box(int lx, int ly, int lz, int hx, int hy, int hz);
            if (lx < 0) lx = 0;
            if (ly < 0) ly = 0;
            if (lz < 0) lz = 0;
            if (hx > dim_of(0) - 1) hx = dim_of(0) - 1;
            if (hy > dim_of(1) - 1) hy = dim_of(1) - 1;
            if (hz > dim_of(2) - 1) hz = dim_of(2) - 1;
            for (int z = lz; z <= hz; z++)
                for (int y = ly; y <= hy; y++)
                    for (int x = lx; x <= hx; x++)
                        stamps[x + y*REGIONS + z*REGIONS*REGIONS] = clock_value;
        endfunction

        function void note_command(command_t it);
            stamp_result_t r;
            int rx, ry, rz;
            r.status       = ST_OK;
            r.region_time  = '0;
            r.write_valid  = 1'b0;
            r.write_x      = '0;
            r.write_y      = '0;
            r.write_z      = '0;
            r.write_value  = '0;
            case (it.cmd)
                CMD_TRACK: begin
                    if (bump_time()) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        r.write_valid = 1'b1;
                        rx = region_of(it.pos_x);
                        ry = region_of(it.pos_y);
                        rz = region_of(it.pos_z);
                        // Face voxels also dirty the neighbors, clamped at region 0 and the volume edge
                        if (on_face(it.pos_x) || on_face(it.pos_y) || on_face(it.pos_z))
                            stamp_box(rx - 1, ry - 1, rz - 1, rx + 1, ry + 1, rz + 1);
                        else
                            stamp_box(rx, ry, rz, rx, ry, rz);
                        if (bump_time()) r.status = ST_OVERFLOW;
                    end
                end
                CMD_LWRITE: begin
                    if (box_held) r.write_valid = 1'b1;
                    else r.status = ST_BAD_LWRITE;
                end
                CMD_LOCK: begin
                    if (box_held) begin
                        r.status = ST_LOCKED;
                    end else begin
                        box_lo   = '{int'(it.pos_x), int'(it.pos_y), int'(it.pos_z)};
                        box_hi   = '{int'(it.up_x), int'(it.up_y), int'(it.up_z)};
                        box_held = 1'b1;
                    end
                end
                CMD_UNLOCK: begin
                    if (!box_held) begin
                        r.status = ST_NOT_LOCKED;
                    end else if (bump_time()) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        stamp_box(region_of(12'(box_lo[0])), region_of(12'(box_lo[1])),
                                  region_of(12'(box_lo[2])), region_of(12'(box_hi[0])),
                                  region_of(12'(box_hi[1])), region_of(12'(box_hi[2])));
                        box_held = 1'b0;
                        if (bump_time()) r.status = ST_OVERFLOW;
                    end
                end
                CMD_MARK: begin
                    if (bump_time()) r.status = ST_OVERFLOW;
                    else stamp_box(0, 0, 0, REGIONS - 1, REGIONS - 1, REGIONS - 1);
                end
                CMD_QUERY: begin
                    if (int'(it.reg_x) < dim_of(0) && int'(it.reg_y) < dim_of(1) &&
                        int'(it.reg_z) < dim_of(2))
                        r.region_time = stamps[it.reg_x + it.reg_y*REGIONS +
                                               it.reg_z*REGIONS*REGIONS];
                end
                default: ;
            endcase
            if (r.write_valid) begin
                r.write_x     = it.pos_x;
                r.write_y     = it.pos_y;
                r.write_z     = it.pos_z;
                r.write_value = it.value;
            end
            r.current_time = clock_value;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            stamp_result_t want;
            if (expected_results.size() == 0) begin
                $error("result beat with no command waiting for it");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("status", 32'(want.status), 32'(tuser[2:0]));
            compare_field("write_valid", 32'(want.write_valid), 32'(tuser[M_FWD_BIT]));
            compare_field("current_time", want.current_time, tdata[31:0]);
            compare_field("region_time", want.region_time, tdata[63:32]);
            compare_field("write_x", 32'(want.write_x), 32'(tdata[75:64]));
            compare_field("write_y", 32'(want.write_y), 32'(tdata[87:76]));
            compare_field("write_z", 32'(want.write_z), 32'(tdata[99:88]));
            compare_field("write_value", 32'(want.write_value), 32'(tdata[107:100]));
        endfunction

        function bit drained();
            return expected_results.size() == 0;
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic [S_TUSER_W-1:0] i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;
    logic                 i_psel;
    logic                 i_penable;
    logic                 i_pwrite;
    logic [3:0]           i_paddr;
    logic [31:0]          i_pwdata;
    logic [31:0]          o_prdata;
    logic                 o_pready;

    region_stamp_scoreboard sb;
    command_t               offered_cmd;
    bit                     calm;
    bit                     hold_request;
    int                     cycle_count;

    region_dirty_timestamp_tracker DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watch both streams; check results before noting the new command
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
            if (i_s_tvalid && o_s_tready) sb.note_command(offered_cmd);
        end
    end

    // Guard against a hung block
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_m_tready = 1'b0;
                repeat (600) @(negedge i_clk);
                hold_request = 1'b0;
            end
            i_m_tready = calm || ($urandom_range(0, 99) >= 11);
        end
    end

    function automatic bit sender_gap();
        return !calm && ($urandom_range(0, 99) < 11);
    endfunction

    function automatic command_t make_command(logic [2:0] cmd, int px, int py, int pz,
                                              int ux, int uy, int uz, int val,
                                              int rx, int ry, int rz);
        command_t it;
        it.cmd   = cmd;
        it.pos_x = 12'(px);
        it.pos_y = 12'(py);
        it.pos_z = 12'(pz);
        it.up_x  = 12'(ux);
        it.up_y  = 12'(uy);
        it.up_z  = 12'(uz);
        it.value = 8'(val);
        it.reg_x = 4'(rx);
        it.reg_y = 4'(ry);
        it.reg_z = 4'(rz);
        return it;
    endfunction

    // Mostly voxels inside the volume, biased to region faces
    function automatic int pick_coord(int dim);
        int side;
        int off;
        if ($urandom_range(0, 9) < 4) return $urandom_range(0, 4095);
        side = 1 << sb.shift_cfg;
        case ($urandom_range(0, 2))
            0:       off = 0;
            1:       off = side - 1;
            default: off = $urandom_range(0, side - 1);
        endcase
        return (($urandom_range(0, dim - 1) << sb.shift_cfg) | off) & 12'hFFF;
    endfunction

    // Favor lock, locked writes, unlock runs; keep the rest as noise
    function automatic command_t random_command();
        command_t it;
        int pick;
        int side;
        int bad_axis;
        int shape;
        int lo [3];
        int hi [3];
        it = make_command(3'($urandom_range(0, 7)), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 255),
                          $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15));
        pick = $urandom_range(0, 999);
        if (sb.box_held) begin
            if (pick < 500)      it.cmd = CMD_LWRITE;
            else if (pick < 650) it.cmd = CMD_UNLOCK;
            else if (pick < 700) it.cmd = CMD_LOCK;
            else if (pick < 850) it.cmd = CMD_TRACK;
            else if (pick < 980) it.cmd = CMD_QUERY;
            else                 it.cmd = $urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B;
        end else begin
            if (pick < 400)      it.cmd = CMD_TRACK;
            else if (pick < 550) it.cmd = CMD_LOCK;
            else if (pick < 580) it.cmd = CMD_UNLOCK;
            else if (pick < 610) it.cmd = CMD_LWRITE;
            else if (pick < 900) it.cmd = CMD_QUERY;
            else if (pick < 915) it.cmd = CMD_MARK;
            else                 it.cmd = $urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B;
        end
        case (it.cmd)
            CMD_TRACK, CMD_LWRITE: begin
                it.pos_x = 12'(pick_coord(sb.dim_of(0)));
                it.pos_y = 12'(pick_coord(sb.dim_of(1)));
                it.pos_z = 12'(pick_coord(sb.dim_of(2)));
            end
            CMD_LOCK: begin
                side  = 1 << sb.shift_cfg;
                shape = $urandom_range(0, 9);
                for (int a = 0; a < 3; a++) begin
                    lo[a] = pick_coord(sb.dim_of(a));
                    hi[a] = lo[a] + ($urandom_range(0, 2) << sb.shift_cfg) +
                            $urandom_range(0, side - 1);
                    if (hi[a] > 4095) hi[a] = 4095;
                end
                // Inverted box on one axis
                if (shape == 8) begin
                    bad_axis     = $urandom_range(0, 2);
                    lo[bad_axis] = $urandom_range(side, 4095);
                    hi[bad_axis] = lo[bad_axis] - side;
                end
                if (shape != 9) begin
                    it.pos_x = 12'(lo[0]);
                    it.pos_y = 12'(lo[1]);
                    it.pos_z = 12'(lo[2]);
                    it.up_x  = 12'(hi[0]);
                    it.up_y  = 12'(hi[1]);
                    it.up_z  = 12'(hi[2]);
                end
            end
            CMD_QUERY: begin
                if ($urandom_range(0, 3) != 0) it.reg_x = 4'($urandom_range(0, sb.dim_of(0) - 1));
                if ($urandom_range(0, 3) != 0) it.reg_y = 4'($urandom_range(0, sb.dim_of(1) - 1));
                if ($urandom_range(0, 3) != 0) it.reg_z = 4'($urandom_range(0, sb.dim_of(2) - 1));
            end
            default: ;
        endcase
        return it;
    endfunction

    // Offer one command beat and hold it until accepted; starts and ends at a falling edge
    task automatic send_command(input command_t it);
        while (sender_gap()) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        offered_cmd = it;
        i_s_tdata   = {4'b0, it.reg_z, it.reg_y, it.reg_x, it.value,
                       it.up_z, it.up_y, it.up_x, it.pos_z, it.pos_y, it.pos_x};
        i_s_tuser   = it.cmd;
        i_s_tvalid  = 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (!sb.drained()) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b1;
        i_paddr   = {idx, 2'b00};
        i_pwdata  = value;
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        sb.write_register(idx, value);
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
    endtask

    task automatic apply_config(input int shift, input int w, input int h, input int d);
        write_register(REG_SHIFT, 32'(shift));
        write_register(REG_WIDTH, 32'(w));
        write_register(REG_HEIGHT, 32'(h));
        write_register(REG_DEPTH, 32'(d));
    endtask

    task automatic run_random(input int count, input int phase);
        for (int n = 0; n < count; n++) begin
            // Stall the result side long enough to back up the input
            if (phase == 2 && n == 100) hold_request = 1'b1;
            // Pause the sender until every result is back
            if (phase == 3 && n == 60) wait_drained();
            send_command(random_command());
        end
        wait_drained();
    endtask

    initial begin
        sb           = new();
        calm         = 1'b0;
        hold_request = 1'b0;
        offered_cmd  = '0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        i_psel       = 1'b0;
        i_penable    = 1'b0;
        i_pwrite     = 1'b0;
        i_paddr      = '0;
        i_pwdata     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: default geometry, every command and each lock error path
        apply_config(4, 16, 16, 16);
        send_command(make_command(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_command(CMD_TRACK, 5, 5, 5, 0, 0, 0, 8'h5A, 0, 0, 0));
        send_command(make_command(CMD_TRACK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_command(CMD_TRACK, 4095, 4095, 4095, 0, 0, 0, 255, 0, 0, 0));
        send_command(make_command(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_command(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 15, 15, 15));
        send_command(make_command(CMD_LWRITE, 7, 8, 9, 0, 0, 0, 1, 0, 0, 0));
        send_command(make_command(CMD_UNLOCK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_command(CMD_LOCK, 16, 16, 16, 47, 47, 47, 0, 0, 0, 0));
        send_command(make_command(CMD_LOCK, 0, 0, 0, 4095, 4095, 4095, 0, 0, 0, 0));
        send_command(make_command(CMD_LWRITE, 4095, 4095, 4095, 0, 0, 0, 255, 0, 0, 0));
        send_command(make_command(CMD_UNLOCK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_command(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 2, 2, 2));
        send_command(make_command(CMD_LOCK, 64, 0, 0, 0, 4095, 4095, 0, 0, 0, 0));
        send_command(make_command(CMD_UNLOCK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_command(CMD_RSVD_A, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10));
        send_command(make_command(CMD_RSVD_B, 4095, 4095, 4095, 4095, 4095, 4095,
                                  255, 15, 15, 15));
        send_command(make_command(CMD_MARK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_command(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 7, 7, 7));
        wait_drained();

        // Directed: 256-voxel regions in a one-region volume
        apply_config(8, 1, 1, 1);
        send_command(make_command(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        send_command(make_command(CMD_TRACK, 0, 0, 0, 0, 0, 0, 3, 0, 0, 0));
        send_command(make_command(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_command(CMD_TRACK, 4095, 4095, 4095, 0, 0, 0, 4, 0, 0, 0));
        send_command(make_command(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 15, 15, 15));
        wait_drained();

        // Random phases over a spread of geometries, extremes first
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       apply_config(0, 16, 16, 16);
                1:       apply_config(8, 16, 16, 16);
                2:       apply_config(1, 1, 16, 2);
                3:       apply_config(4, 16, 1, 16);
                default: apply_config($urandom_range(0, 8), $urandom_range(1, 16),
                                      $urandom_range(1, 16), $urandom_range(1, 16));
            endcase
            calm = (phase == 4);
            run_random(225, phase);
            calm = 1'b0;
        end

        // Drain and let the block settle
        wait_drained();
        repeat (64) @(posedge i_clk);
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
